// ===== sv/serial_command_frame_parser_core_defines.svh =====
// Assertion macros shared by the frame parser RTL.
`ifndef SERIAL_COMMAND_FRAME_PARSER_CORE_DEFINES_SVH
`define SERIAL_COMMAND_FRAME_PARSER_CORE_DEFINES_SVH

// Clocked assertion, disabled while in reset.
`define SCFP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define SCFP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/scfp_pkg.sv =====
// Types and constants of the serial command frame parser.
package scfp_pkg;

  localparam logic [7:0] SYNC_FIRST  = 8'hDE;
  localparam logic [7:0] SYNC_SECOND = 8'hAD;
  localparam logic [7:0] TAIL_FIRST  = 8'hBE;
  localparam logic [7:0] TAIL_SECOND = 8'hEF;
  localparam logic [8:0] HDR_BYTES   = 9'd4;

  localparam logic [8:0] POS_SYNC0 = 9'd0;
  localparam logic [8:0] POS_SYNC1 = 9'd1;
  localparam logic [8:0] POS_CMD   = 9'd2;
  localparam logic [8:0] POS_LEN   = 9'd3;

  localparam logic [7:0] CMD_COUNT_RESET = 8'd4;
  localparam logic       REG_CMD_COUNT   = 1'b0;

  typedef enum logic [1:0] {
    ST_CONTINUE = 2'd0,
    ST_PAYLOAD  = 2'd1,
    ST_DONE     = 2'd2,
    ST_ERROR    = 2'd3
  } status_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
    logic [7:0] command;
    logic [7:0] payload_length;
  } result_t;

endpackage

// ===== sv/scfp_cfg.sv =====
// APB-style register file holding the command count.
module scfp_cfg (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready,
  output logic [7:0]  command_count
);

  logic [7:0] cmd_count_r;
  logic [7:0] cmd_count_nxt;
  logic       wr_en;

  assign cfg_pready = 1'b1;
  assign wr_en = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                 && (cfg_paddr[2] == scfp_pkg::REG_CMD_COUNT);

  always_comb begin
    cmd_count_nxt = cmd_count_r;
    if (wr_en) begin
      cmd_count_nxt = cfg_pwdata[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_count_r <= scfp_pkg::CMD_COUNT_RESET;
    end else begin
      cmd_count_r <= cmd_count_nxt;
    end
  end

  always_comb begin
    cfg_prdata = 32'd0;
    if (cfg_paddr[2] == scfp_pkg::REG_CMD_COUNT) begin
      cfg_prdata = {24'd0, cmd_count_r};
    end
  end

  assign command_count = cmd_count_r;

endmodule

// ===== sv/scfp_parse.sv =====
// Frame position tracking and per-byte decode of the parser.
module scfp_parse (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic [7:0]          rx_byte,
  input  logic [7:0]          command_count,
  output scfp_pkg::result_t   result
);

  logic [8:0] pos_r, pos_nxt;
  logic [7:0] cmd_r, cmd_nxt;
  logic [7:0] len_r, len_nxt;
  logic [8:0] end0;
  logic [8:0] end1;
  logic [8:0] pidx;
  logic       clr;

  assign end0 = {1'b0, len_r} + scfp_pkg::HDR_BYTES;
  assign end1 = end0 + 9'd1;
  assign pidx = pos_r - scfp_pkg::HDR_BYTES;

  always_comb begin
    pos_nxt = pos_r;
    cmd_nxt = cmd_r;
    len_nxt = len_r;
    clr     = 1'b0;
    result.status        = scfp_pkg::ST_CONTINUE;
    result.payload_byte  = 8'd0;
    result.payload_index = 8'd0;
    if (pos_r == scfp_pkg::POS_SYNC0) begin
      if (rx_byte != scfp_pkg::SYNC_FIRST) begin
        result.status = scfp_pkg::ST_ERROR;
        clr = 1'b1;
      end else begin
        pos_nxt = scfp_pkg::POS_SYNC1;
      end
    end else if (pos_r == scfp_pkg::POS_SYNC1) begin
      if (rx_byte != scfp_pkg::SYNC_SECOND) begin
        result.status = scfp_pkg::ST_ERROR;
        clr = 1'b1;
      end else begin
        pos_nxt = scfp_pkg::POS_CMD;
      end
    end else if (pos_r == scfp_pkg::POS_CMD) begin
      if (rx_byte >= command_count) begin
        result.status = scfp_pkg::ST_ERROR;
        clr = 1'b1;
      end else begin
        cmd_nxt = rx_byte;
        pos_nxt = scfp_pkg::POS_LEN;
      end
    end else if (pos_r == scfp_pkg::POS_LEN) begin
      len_nxt = rx_byte;
      pos_nxt = scfp_pkg::HDR_BYTES;
    end else if (pos_r == end0) begin
      if (rx_byte != scfp_pkg::TAIL_FIRST) begin
        result.status = scfp_pkg::ST_ERROR;
        clr = 1'b1;
      end else begin
        pos_nxt = pos_r + 9'd1;
      end
    end else if (pos_r == end1) begin
      result.status = (rx_byte != scfp_pkg::TAIL_SECOND) ? scfp_pkg::ST_ERROR
                                                           : scfp_pkg::ST_DONE;
      clr = 1'b1;
    end else begin
      result.status        = scfp_pkg::ST_PAYLOAD;
      result.payload_byte  = rx_byte;
      result.payload_index = pidx[7:0];
      pos_nxt = pos_r + 9'd1;
    end
    // command and length are reported as held before the clear
    result.command        = cmd_nxt;
    result.payload_length = len_nxt;
    if (clr) begin
      pos_nxt = 9'd0;
      cmd_nxt = 8'd0;
      len_nxt = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= 9'd0;
      cmd_r <= 8'd0;
      len_r <= 8'd0;
    end else if (accept) begin
      pos_r <= pos_nxt;
      cmd_r <= cmd_nxt;
      len_r <= len_nxt;
    end
  end

endmodule

// ===== sv/serial_command_frame_parser_core.sv =====
// Result: the result of an input transaction is on the output register in the cycle after it.
// Throughput: one byte per cycle; the frame state update is a single compare
// chain on the current position, and the output register accepts a new byte
// whenever it is empty or being drained in the same cycle.
// Reset: synchronous active-low; parser state clears, command count returns to 4.
`include "serial_command_frame_parser_core_defines.svh"

module serial_command_frame_parser_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [7:0]  out_payload_byte,
  output logic [7:0]  out_payload_index,
  output logic [7:0]  out_command,
  output logic [7:0]  out_payload_length,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic              accept;
  logic [7:0]        command_count;
  scfp_pkg::result_t step_res;
  scfp_pkg::result_t out_res_r;
  logic              out_valid_r, out_valid_nxt;

  scfp_cfg u_cfg (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_psel      (cfg_psel),
    .cfg_penable   (cfg_penable),
    .cfg_pwrite    (cfg_pwrite),
    .cfg_paddr     (cfg_paddr),
    .cfg_pwdata    (cfg_pwdata),
    .cfg_prdata    (cfg_prdata),
    .cfg_pready    (cfg_pready),
    .command_count (command_count)
  );

  scfp_parse u_parse (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .rx_byte       (in_rx_byte),
    .command_count (command_count),
    .result        (step_res)
  );

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_res_r <= step_res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_res_r.status;
  assign out_payload_byte   = out_res_r.payload_byte;
  assign out_payload_index  = out_res_r.payload_index;
  assign out_command        = out_res_r.command;
  assign out_payload_length = out_res_r.payload_length;

  `SCFP_ASSERT(a_accept_fills, accept |=> out_valid_r, "accepted byte produced no result")
  `SCFP_ASSERT(a_pidx_in_len, out_valid_r && out_status == scfp_pkg::ST_PAYLOAD |-> out_payload_index < out_payload_length, "payload index beyond declared length")
  `SCFP_ASSERT(a_nonpayload_zero, out_valid_r && out_status != scfp_pkg::ST_PAYLOAD |-> out_payload_byte == 8'd0 && out_payload_index == 8'd0, "payload fields set outside payload")
  `SCFP_ASSERT_ALWAYS(a_reset_empty, !$past(rst_n) |-> !out_valid_r, "result valid right after reset")

endmodule
